// ===== sv/indexed_binary_min_heap_defines.svh =====
// ----------------------------------------------------------------------------
// indexed_binary_min_heap_defines
// Assertion macros used by the heap RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_BINARY_MIN_HEAP_DEFINES_SVH
`define INDEXED_BINARY_MIN_HEAP_DEFINES_SVH

// Check that a condition implies a consequence on the same edge.
`define IBMH_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("heap check failed");

// Check that a condition implies a consequence on the next edge.
`define IBMH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("heap check failed");

`endif

// ===== sv/ibmh_pkg.sv =====
// ----------------------------------------------------------------------------
// ibmh_pkg
// Shared types and constants of the indexed binary min-heap.
// ----------------------------------------------------------------------------
package ibmh_pkg;
	localparam int CAPACITY  = 1024;
	localparam int DIST_BITS = 32;
	localparam int VTX_SPAN  = 1024;
	localparam int VTX_W     = 10;
	localparam int DIST_W    = 32;
	localparam int SLOT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W    = $clog2(CAPACITY + 1);
	localparam int CNT_W     = 11;
	localparam int ENTRY_W   = VTX_W + DIST_BITS;

	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_BUILD   = 2'd1;
	localparam logic [1:0] FUNC_EXTRACT = 2'd2;
	localparam logic [1:0] FUNC_DECR    = 2'd3;

	localparam logic [1:0] ERR_OK     = 2'd0;
	localparam logic [1:0] ERR_EMPTY  = 2'd1;
	localparam logic [1:0] ERR_FULL   = 2'd2;
	localparam logic [1:0] ERR_ABSENT = 2'd3;

	typedef struct packed {
		logic [1:0]        func;
		logic [VTX_W-1:0]  vertex_id;
		logic [DIST_W-1:0] distance;
	} req_t;

	typedef struct packed {
		logic [VTX_W-1:0]  out_vertex;
		logic [DIST_W-1:0] out_distance;
		logic              found;
		logic [1:0]        error;
		logic [CNT_W-1:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic [VTX_W-1:0]     vertex;
		logic [DIST_BITS-1:0] key;
	} entry_t;
endpackage

// ===== sv/ibmh_req_if.sv =====
// ----------------------------------------------------------------------------
// ibmh_req_if
// Request channel of the heap: valid, ready and one operation.
// ----------------------------------------------------------------------------
interface ibmh_req_if;
	logic           valid;
	logic           ready;
	ibmh_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/ibmh_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ibmh_rsp_if
// Response channel of the heap: valid, ready and one result.
// ----------------------------------------------------------------------------
interface ibmh_rsp_if;
	logic           valid;
	logic           ready;
	ibmh_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/indexed_binary_min_heap.sv =====
// ----------------------------------------------------------------------------
// indexed_binary_min_heap
// Priority queue with decrease-key for shortest-path search.
// ----------------------------------------------------------------------------
// One request at a time. Entries live in a single-port heap RAM indexed by
// slot and a single-port position RAM indexed by vertex, each with
// registered read data. A load writes the entry and its position, then
// answers. An extract reads the root and the last entry, writes the last
// entry into the root and sifts it down. Decrease-key reads the position
// and the entry, writes a smaller key and sifts the entry up. Build sifts
// down every inner node from the last one back to the root. A full heap or
// an empty extract answers without touching the RAMs, an absent vertex once
// its position and entry are read. The response needs its handshake
// before the next request is taken.
`include "indexed_binary_min_heap_defines.svh"

module indexed_binary_min_heap (
	input logic        clk,
	input logic        arst_n,
	ibmh_req_if.sink   req,
	ibmh_rsp_if.source rsp
);
	localparam int SW = ibmh_pkg::SLOT_W;
	localparam int AW = ibmh_pkg::ADDR_W;
	localparam int DB = ibmh_pkg::DIST_BITS;
	localparam int VW = ibmh_pkg::VTX_W;
	localparam int CW = ibmh_pkg::CNT_W;
	localparam int HDEPTH = 1 << AW;

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_LOAD   = 5'd1;
	localparam logic [4:0] ST_EX_RL  = 5'd2;  // read root
	localparam logic [4:0] ST_EX_WL  = 5'd3;  // read last
	localparam logic [4:0] ST_EX_WR  = 5'd4;  // write last into root
	localparam logic [4:0] ST_DN_RI  = 5'd5;  // read node i
	localparam logic [4:0] ST_DN_RL  = 5'd6;  // read left
	localparam logic [4:0] ST_DN_RR  = 5'd7;  // read right
	localparam logic [4:0] ST_DN_CMP = 5'd8;
	localparam logic [4:0] ST_SW_A   = 5'd9;  // write slot a, pos of b entry
	localparam logic [4:0] ST_SW_B   = 5'd10; // write slot b, pos of a entry
	localparam logic [4:0] ST_DK_P   = 5'd11; // read position
	localparam logic [4:0] ST_DK_E   = 5'd12; // read entry
	localparam logic [4:0] ST_DK_CHK = 5'd13;
	localparam logic [4:0] ST_UP_RP  = 5'd14; // read parent
	localparam logic [4:0] ST_UP_CMP = 5'd15;
	localparam logic [4:0] ST_DONE   = 5'd16;
	localparam logic [4:0] ST_WAIT   = 5'd17;
	localparam logic [4:0] ST_EX_POS = 5'd18;

	logic [4:0] state_q;
	logic [CW-1:0] total_q;
	ibmh_pkg::req_t req_q;
	logic build_q, upmode_q;
	logic [SW-1:0] bidx_q;     // next build node
	logic [SW-1:0] i_q, s_q;   // current slot and swap partner
	ibmh_pkg::entry_t ei_q, es_q;
	logic [SW-1:0] pos_q;

	// heap RAM port
	logic h_we;
	logic [AW-1:0] h_addr;
	ibmh_pkg::entry_t h_wdata, h_rdata;
	// position RAM port
	logic p_we;
	logic [VW-1:0] p_addr;
	logic [SW-1:0] p_wdata, p_rdata;

	ibmh_pkg::rsp_t rsp_q;
	logic rsp_valid_q;

	ibmh_ram #(.WIDTH(ibmh_pkg::ENTRY_W), .DEPTH(HDEPTH)) u_heap (
		.clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
	);
	ibmh_ram #(.WIDTH(SW), .DEPTH(ibmh_pkg::VTX_SPAN)) u_pos (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
	);

	assign req.ready   = (state_q == ST_IDLE) && !rsp_valid_q;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	logic [SW:0] l_slot, r_slot;
	logic [SW:0] tot_ext;
	assign l_slot  = {i_q, 1'b0};
	assign r_slot  = {i_q, 1'b1};
	assign tot_ext = (SW + 1)'(total_q);

	// address and write muxing per state
	always_comb begin
		h_we = 1'b0; h_addr = '0; h_wdata = '0;
		p_we = 1'b0; p_addr = '0; p_wdata = '0;
		unique case (state_q)
			ST_LOAD: begin
				h_we = 1'b1; h_addr = AW'(total_q);
				h_wdata.vertex = req_q.vertex_id;
				h_wdata.key = req_q.distance[DB-1:0];
				p_we = 1'b1; p_addr = req_q.vertex_id; p_wdata = SW'(total_q);
			end
			ST_EX_RL:  h_addr = AW'(1);
			ST_EX_WL:  h_addr = AW'(total_q);
			ST_EX_WR: begin
				h_we = 1'b1; h_addr = AW'(1); h_wdata = h_rdata;
			end
			ST_EX_POS: begin
				p_we = 1'b1; p_addr = es_q.vertex; p_wdata = SW'(1);
			end
			ST_DN_RI:  h_addr = AW'(i_q);
			ST_DN_RL:  h_addr = AW'(l_slot);
			ST_DN_RR:  h_addr = AW'(r_slot);
			ST_SW_A: begin
				h_we = 1'b1; h_addr = AW'(i_q); h_wdata = es_q;
				p_we = 1'b1; p_addr = es_q.vertex; p_wdata = i_q;
			end
			ST_SW_B: begin
				h_we = 1'b1; h_addr = AW'(s_q); h_wdata = ei_q;
				p_we = 1'b1; p_addr = ei_q.vertex; p_wdata = s_q;
			end
			ST_DK_P:   p_addr = req_q.vertex_id;
			ST_DK_E:   h_addr = AW'(p_rdata);
			ST_DK_CHK: begin
				h_addr = AW'(pos_q);
				h_we = (pos_q != '0) && (CW'(pos_q) <= total_q)
					&& (h_rdata.vertex == req_q.vertex_id)
					&& (req_q.distance[DB-1:0] < h_rdata.key);
				h_wdata.vertex = req_q.vertex_id;
				h_wdata.key = req_q.distance[DB-1:0];
			end
			ST_UP_RP:  h_addr = AW'(s_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			req_q       <= '0;
			build_q     <= 1'b0;
			upmode_q    <= 1'b0;
			bidx_q      <= '0;
			i_q         <= '0;
			s_q         <= '0;
			ei_q        <= '0;
			es_q        <= '0;
			pos_q       <= '0;
		end else begin
			// clear the response once it is taken
			if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
				rsp_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						req_q <= req.payload;
						build_q <= (req.payload.func == ibmh_pkg::FUNC_BUILD);
						upmode_q <= 1'b0;
						unique case (req.payload.func)
							ibmh_pkg::FUNC_LOAD: begin
								if (total_q >= CW'(ibmh_pkg::CAPACITY)) begin
									rsp_q.error <= ibmh_pkg::ERR_FULL;
									state_q <= ST_DONE;
								end else begin
									total_q <= total_q + CW'(1);
									state_q <= ST_LOAD;
								end
							end
							ibmh_pkg::FUNC_BUILD: begin
								bidx_q <= SW'(total_q >> 1);
								state_q <= ST_WAIT;
							end
							ibmh_pkg::FUNC_EXTRACT: begin
								if (total_q == '0) begin
									rsp_q.error <= ibmh_pkg::ERR_EMPTY;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_EX_RL;
								end
							end
							default: state_q <= ST_DK_P;
						endcase
					end
				end
				ST_LOAD: state_q <= ST_DONE;
				ST_EX_RL: state_q <= ST_EX_WL;
				ST_EX_WL: begin
					rsp_q.out_vertex <= h_rdata.vertex;
					rsp_q.out_distance <= DB'(h_rdata.key);
					rsp_q.found <= 1'b1;
					state_q <= ST_EX_WR;
				end
				ST_EX_WR: begin
					// h_rdata now holds the last entry (read in EX_WL)
					es_q <= h_rdata;
					state_q <= ST_EX_POS;
				end
				ST_EX_POS: begin
					total_q <= total_q - CW'(1);
					i_q <= SW'(1);
					state_q <= ST_DN_RI;
				end
				ST_WAIT: begin
					// next build node, or finish
					if (bidx_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						i_q <= bidx_q;
						bidx_q <= bidx_q - SW'(1);
						state_q <= ST_DN_RI;
					end
				end
				ST_DN_RI: begin
					if (l_slot > tot_ext) begin
						state_q <= build_q ? ST_WAIT : ST_DONE;
					end else begin
						state_q <= ST_DN_RL;
					end
				end
				ST_DN_RL: begin
					ei_q <= h_rdata;
					state_q <= ST_DN_RR;
				end
				ST_DN_RR: begin
					// left data arrives
					if (h_rdata.key < ei_q.key) begin
						es_q <= h_rdata; s_q <= SW'(l_slot);
					end else begin
						es_q <= ei_q; s_q <= i_q;
					end
					state_q <= ST_DN_CMP;
				end
				ST_DN_CMP: begin
					if (r_slot <= tot_ext && h_rdata.key < es_q.key) begin
						es_q <= h_rdata; s_q <= SW'(r_slot);
						state_q <= ST_SW_A;
					end else if (s_q == i_q) begin
						state_q <= build_q ? ST_WAIT : ST_DONE;
					end else begin
						state_q <= ST_SW_A;
					end
				end
				ST_SW_A: state_q <= ST_SW_B;
				ST_SW_B: begin
					if (upmode_q) begin
						// continue upward from parent slot s
						i_q <= s_q;
						ei_q <= ei_q;
						if (s_q == SW'(1)) begin
							state_q <= ST_DONE;
						end else begin
							s_q <= s_q >> 1;
							state_q <= ST_UP_RP;
						end
					end else begin
						i_q <= s_q;
						state_q <= ST_DN_RI;
					end
				end
				ST_DK_P: state_q <= ST_DK_E;
				ST_DK_E: begin
					pos_q <= p_rdata;
					state_q <= ST_DK_CHK;
				end
				ST_DK_CHK: begin
					if (pos_q == '0 || CW'(pos_q) > total_q
						|| h_rdata.vertex != req_q.vertex_id) begin
						rsp_q.error <= ibmh_pkg::ERR_ABSENT;
						state_q <= ST_DONE;
					end else if (req_q.distance[DB-1:0] < h_rdata.key
						&& pos_q != SW'(1)) begin
						upmode_q <= 1'b1;
						i_q <= pos_q;
						s_q <= pos_q >> 1;
						ei_q.vertex <= req_q.vertex_id;
						ei_q.key <= req_q.distance[DB-1:0];
						state_q <= ST_UP_RP;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_UP_RP: state_q <= ST_UP_CMP;
				ST_UP_CMP: begin
					// SW_A writes es (parent) at i, SW_B writes ei (moving) at s
					if (ei_q.key < h_rdata.key) begin
						es_q <= h_rdata;
						state_q <= ST_SW_A;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					rsp_q.entry_count <= total_q;
					rsp_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`IBMH_ASSERT_IMPL(a_ready_idle, req.ready, state_q == ST_IDLE)
	`IBMH_ASSERT_NEXT(a_done_valid, state_q == ST_DONE, rsp_valid_q)
	`IBMH_ASSERT_IMPL(a_count_cap, 1'b1, total_q <= CW'(ibmh_pkg::CAPACITY))
	`IBMH_ASSERT_IMPL(a_swap_diff, state_q == ST_SW_A, s_q != i_q)
endmodule

// ===== sv/ibmh_ram.sv =====
// ----------------------------------------------------------------------------
// ibmh_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ibmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== tb/ibmh_heap_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ibmh_heap_checker
// Tracks the heap from accepted requests, works out each response and
// compares the block's responses with it field by field, in order.
// ----------------------------------------------------------------------------
module ibmh_heap_checker
	import ibmh_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	ibmh_req_if    req,
	ibmh_rsp_if    rsp,
	output int     fail_count,
	output int     pending
);
	logic [VTX_W-1:0]     heap_vtx [1:CAPACITY];
	logic [DIST_BITS-1:0] heap_key [1:CAPACITY];
	int unsigned          slot_of [0:VTX_SPAN-1];
	int unsigned          heap_size;
	rsp_t                 awaited_rsp [$];

	function automatic void swap_slots(int unsigned a, int unsigned b);
		logic [VTX_W-1:0]     tv;
		logic [DIST_BITS-1:0] tk;
		tv = heap_vtx[a]; tk = heap_key[a];
		heap_vtx[a] = heap_vtx[b]; heap_key[a] = heap_key[b];
		heap_vtx[b] = tv; heap_key[b] = tk;
		slot_of[heap_vtx[a]] = a;
		slot_of[heap_vtx[b]] = b;
	endfunction

	function automatic void sift_down(int unsigned i);
		int unsigned l, r, s;
		forever begin
			l = 2 * i;
			r = l + 1;
			s = i;
			if (l <= heap_size && heap_key[l] < heap_key[s]) s = l;
			if (r <= heap_size && heap_key[r] < heap_key[s]) s = r;
			if (s == i) break;
			swap_slots(i, s);
			i = s;
		end
	endfunction

	function automatic void sift_up(int unsigned i);
		while (i > 1 && heap_key[i] < heap_key[i / 2]) begin
			swap_slots(i, i / 2);
			i = i / 2;
		end
	endfunction

	function automatic rsp_t predict_response(req_t r);
		rsp_t        o;
		int unsigned p;
		o = '0;
		case (r.func)
			FUNC_LOAD: begin
				if (heap_size >= CAPACITY) o.error = ERR_FULL;
				else begin
					heap_size++;
					heap_vtx[heap_size] = r.vertex_id;
					heap_key[heap_size] = r.distance;
					slot_of[r.vertex_id] = heap_size;
				end
			end
			FUNC_BUILD: begin
				for (int unsigned i = heap_size / 2; i > 0; i--) sift_down(i);
			end
			FUNC_EXTRACT: begin
				if (heap_size == 0) o.error = ERR_EMPTY;
				else begin
					o.out_vertex   = heap_vtx[1];
					o.out_distance = heap_key[1];
					o.found        = 1'b1;
					heap_vtx[1] = heap_vtx[heap_size];
					heap_key[1] = heap_key[heap_size];
					slot_of[heap_vtx[1]] = 1;
					heap_size--;
					sift_down(1);
				end
			end
			default: begin
				p = slot_of[r.vertex_id];
				if (p < 1 || p > heap_size || heap_vtx[p] != r.vertex_id)
					o.error = ERR_ABSENT;
				else if (r.distance < heap_key[p]) begin
					heap_key[p] = r.distance;
					sift_up(p);
				end
			end
		endcase
		o.entry_count = heap_size[CNT_W-1:0];
		return o;
	endfunction

	assign pending = awaited_rsp.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			heap_size  = 0;
			fail_count = 0;
			awaited_rsp.delete();
		end else begin
			if (req.valid && req.ready)
				awaited_rsp.push_back(predict_response(req.payload));
			if (rsp.valid && rsp.ready) begin
				if (awaited_rsp.size() == 0) begin
					$display("%0t: response with none awaited: %p", $time, rsp.payload);
					fail_count++;
				end else begin
					e = awaited_rsp.pop_front();
					if (rsp.payload !== e) begin
						$display({"%0t: mismatch vtx %0d/%0d dist %h/%h found %b/%b ",
							"err %0d/%0d cnt %0d/%0d (expected/actual)"},
							$time, e.out_vertex, rsp.payload.out_vertex, e.out_distance,
							rsp.payload.out_distance, e.found, rsp.payload.found,
							e.error, rsp.payload.error, e.entry_count, rsp.payload.entry_count);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives heap requests (directed corners, then random mixes under varying
// back-pressure, including filling the heap to capacity) and gives the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
	import ibmh_pkg::*;

	localparam int STALL_LIMIT = 100000;

	logic clk;
	logic arst_n;
	int   fail_count, pending;
	int   tx_idle_pct, rx_idle_pct;
	int   stall_cycles;
	int   shadow_count;
	int   req_total;
	logic [VTX_W-1:0] loaded_vtx [$];
	bit   full_seen;

	ibmh_req_if req ();
	ibmh_rsp_if rsp ();

	indexed_binary_min_heap dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	ibmh_heap_checker checker_i (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk)
		rsp.ready <= ($urandom_range(99) >= rx_idle_pct);

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_op(logic [1:0] f, logic [VTX_W-1:0] v, logic [DIST_W-1:0] d);
		while ($urandom_range(99) < tx_idle_pct) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.valid   = 1'b1;
		req.payload = '{func: f, vertex_id: v, distance: d};
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		req.valid = 1'b0;
		req_total++;
		case (f)
			FUNC_LOAD: begin
				if (shadow_count < CAPACITY) shadow_count++;
				else full_seen = 1'b1;
				loaded_vtx.push_back(v);
			end
			FUNC_EXTRACT: if (shadow_count > 0) shadow_count--;
			default: ;
		endcase
	endtask

	function automatic logic [DIST_W-1:0] pick_dist();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return $urandom_range(15);
			3: return {16'($urandom_range(3)), 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [VTX_W-1:0] pick_vtx();
		return VTX_W'($urandom_range(VTX_SPAN - 1));
	endfunction

	// decrease-key only names vertices that were loaded at some point
	task automatic random_op(int target);
		int w;
		w = $urandom_range(99);
		if (shadow_count > target && w < 40) w = 60;
		if (w < 40 || loaded_vtx.size() == 0)
			send_op(FUNC_LOAD, pick_vtx(), pick_dist());
		else if (w < 48)
			send_op(FUNC_BUILD, pick_vtx(), $urandom);
		else if (w < 75)
			send_op(FUNC_EXTRACT, pick_vtx(), $urandom);
		else
			send_op(FUNC_DECR, loaded_vtx[$urandom_range(loaded_vtx.size() - 1)],
				pick_dist());
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	initial begin
		arst_n       = 1'b0;
		req.valid    = 1'b0;
		req.payload  = '0;
		rsp.ready    = 1'b0;
		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		stall_cycles = 0;
		shadow_count = 0;
		req_total    = 0;
		full_seen    = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty-heap corners, duplicates, ties, loads after build
		send_op(FUNC_EXTRACT, 10'd3, 32'd0);
		send_op(FUNC_BUILD, 10'd0, 32'd0);
		send_op(FUNC_LOAD, 10'd1023, 32'hFFFF_FFFF);
		send_op(FUNC_LOAD, 10'd0, 32'd0);
		send_op(FUNC_LOAD, 10'd5, 32'h0001_0000);
		send_op(FUNC_LOAD, 10'd5, 32'h0000_8000);
		send_op(FUNC_LOAD, 10'd512, 32'h0001_0000);
		send_op(FUNC_LOAD, 10'd341, 32'h0001_0000);
		send_op(FUNC_BUILD, 10'd0, 32'd0);
		send_op(FUNC_DECR, 10'd1023, 32'd0);
		send_op(FUNC_DECR, 10'd5, 32'hFFFF_FFFF);
		send_op(FUNC_DECR, 10'd512, 32'h0001_0000);
		send_op(FUNC_EXTRACT, 10'd0, 32'd0);
		send_op(FUNC_EXTRACT, 10'd0, 32'd0);
		send_op(FUNC_DECR, 10'd0, 32'd1);
		send_op(FUNC_LOAD, 10'd682, 32'd1);
		send_op(FUNC_DECR, 10'd682, 32'd0);
		send_op(FUNC_EXTRACT, 10'd0, 32'd0);
		send_op(FUNC_BUILD, 10'd0, 32'd0);
		repeat (6) send_op(FUNC_EXTRACT, 10'd0, 32'd0);
		drain();

		tx_idle_pct = 32;
		rx_idle_pct = 81;
		repeat (200) random_op(40);

		// hold off until every response is back
		while (pending != 0) @(negedge clk);

		tx_idle_pct = 81;
		rx_idle_pct = 32;
		while (shadow_count < CAPACITY)
			send_op(FUNC_LOAD, pick_vtx(), pick_dist());
		repeat (3) send_op(FUNC_LOAD, pick_vtx(), pick_dist());
		send_op(FUNC_BUILD, 10'd0, 32'd0);
		repeat (60) random_op(CAPACITY);
		send_op(FUNC_BUILD, 10'd0, 32'd0);
		while (shadow_count > 900) send_op(FUNC_EXTRACT, 10'd0, 32'd0);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (200) random_op(25);
		drain();

		$display("Covered %0d requests: empty/full errors, absent vertices, builds,",
			req_total);
		$display("capacity fill reached=%0b, decrease-key and extraction under stalls.",
			full_seen);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+sv
sv/ibmh_pkg.sv
sv/ibmh_req_if.sv
sv/ibmh_rsp_if.sv
sv/ibmh_ram.sv
sv/indexed_binary_min_heap.sv
tb/ibmh_heap_checker.sv
tb/tb_top.sv
